[src/fra_pkg.sv]
// Shared constants, register indexes and controller/datapath handshake types.
package fra_pkg;

	localparam int DEF_HISTORY_DEPTH = 256;
	localparam int DEF_PRICE_BITS    = 32;

	localparam int LB_W   = 8;
	localparam int RA_W   = 8;
	localparam int TOL_W  = 12;
	localparam int CFG_W  = 12;
	localparam int IDX_W  = 2;
	localparam int FRAC_W = 16;

	// 0.382 and 0.618 as 16-bit fractions, nearest
	localparam logic [FRAC_W-1:0] FRAC_382 = 16'd25035;
	localparam logic [FRAC_W-1:0] FRAC_618 = 16'd40501;

	localparam logic [LB_W-1:0]  RST_SWING_LOOKBACK     = 8'd80;
	localparam logic [RA_W-1:0]  RST_RANGE_AVG_LENGTH   = 8'd14;
	localparam logic [TOL_W-1:0] RST_TOLERANCE_MULTIPLE = 12'd128;

	typedef enum logic [IDX_W-1:0] {
		REG_SWING_LOOKBACK     = 2'd0,
		REG_RANGE_AVG_LENGTH   = 2'd1,
		REG_TOLERANCE_MULTIPLE = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic take;
		logic walk;
		logic div_start;
		logic mul;
		logic lvl;
		logic load;
	} fra_cmd_t;

	typedef struct packed {
		logic accepted;
		logic first_bar;
		logic walk_end;
		logic pipe_busy;
		logic swing_ok;
		logic div_done;
		logic out_free;
	} fra_sts_t;

endpackage

[src/fra_if.sv]
// Bar request and result request channel interfaces.
interface fra_bar_if import fra_pkg::*; #(
	parameter int PRICE_BITS = DEF_PRICE_BITS
);
	logic                  valid;
	logic                  ready;
	logic [PRICE_BITS-1:0] bar_high;
	logic [PRICE_BITS-1:0] bar_low;
	logic [PRICE_BITS-1:0] bar_close;

	modport source (output valid, output bar_high, output bar_low, output bar_close,
		input ready);
	modport sink (input valid, input bar_high, input bar_low, input bar_close,
		output ready);
endinterface

interface fra_res_if import fra_pkg::*; #(
	parameter int PRICE_BITS = DEF_PRICE_BITS
);
	logic                  valid;
	logic                  ready;
	logic [1:0]            confluence_count;
	logic [PRICE_BITS-1:0] level_382;
	logic [PRICE_BITS-1:0] level_618;

	modport source (output valid, output confluence_count, output level_382,
		output level_618, input ready);
	modport sink (input valid, input confluence_count, input level_382,
		input level_618, output ready);
endinterface

[src/fra_div.sv]
// Restoring divider, one quotient bit per cycle.
module fra_div import fra_pkg::*; #(
	parameter int DVD_W = DEF_PRICE_BITS + $clog2(DEF_HISTORY_DEPTH + 1),
	parameter int DVS_W = $clog2(DEF_HISTORY_DEPTH + 1),
	parameter int QUO_W = DEF_PRICE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [QUO_W-1:0] quotient
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [DVD_W-1:0]  acc_q;
	logic [DVS_W-1:0]  rem_q;
	logic [DVS_W:0]    rem_sh;
	logic              ge;
	logic [DVS_W:0]    rem_nx;

	assign rem_sh = {rem_q, acc_q[DVD_W-1]};
	assign ge     = rem_sh >= {1'b0, divisor};
	assign rem_nx = ge ? rem_sh - {1'b0, divisor} : rem_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder stays below the divisor, so the top bit of rem_nx is always clear
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			acc_q <= {acc_q[DVD_W-2:0], ge};
			rem_q <= rem_nx[DVS_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = acc_q[QUO_W-1:0];

endmodule

[src/fra_ctrl.sv]
// Sequencing state machine: accept, history walk, divide, levels, result.
module fra_ctrl import fra_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  fra_sts_t sts,
	output fra_cmd_t cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_WALK  = 7'b0000010,
		S_FLUSH = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_MUL   = 7'b0010000,
		S_LVL   = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				cmd.take = 1'b1;
				if (sts.accepted && !sts.first_bar) state_d = S_WALK;
			end
			S_WALK: begin
				cmd.walk = 1'b1;
				if (sts.walk_end) state_d = S_FLUSH;
			end
			S_FLUSH: begin
				// drop the bar when the swing is flat or inverted
				if (!sts.pipe_busy) begin
					if (sts.swing_ok) begin
						cmd.div_start = 1'b1;
						state_d       = S_DIV;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			S_DIV: begin
				if (sts.div_done) state_d = S_MUL;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_LVL;
			end
			S_LVL: begin
				cmd.lvl = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

[src/fra_datapath.sv]
// Bar history memories, swing/true-range walk, divider, levels and result register.
module fra_datapath import fra_pkg::*; #(
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
	parameter int PRICE_BITS    = DEF_PRICE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	fra_bar_if.sink          bar_in,
	fra_res_if.source        res_out,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  fra_cmd_t         cmd,
	output fra_sts_t         sts
);

	localparam int AW    = $clog2(HISTORY_DEPTH);
	localparam int CW    = $clog2(HISTORY_DEPTH + 1);
	localparam int CNTW  = (CW > LB_W + 1) ? CW : LB_W + 1;
	localparam int SW    = PRICE_BITS + CW;
	localparam int LIMW  = PRICE_BITS + TOL_W;
	localparam int PRODW = PRICE_BITS + FRAC_W;

	logic [LB_W-1:0]  lb_q;
	logic [RA_W-1:0]  ra_q;
	logic [TOL_W-1:0] tol_q;

	logic [PRICE_BITS-1:0] hi_mem [HISTORY_DEPTH];
	logic [PRICE_BITS-1:0] lo_mem [HISTORY_DEPTH];
	logic [PRICE_BITS-1:0] cl_mem [HISTORY_DEPTH];

	logic            accept;
	logic [AW-1:0]   wptr_q;
	logic [CW-1:0]   bars_q;
	logic [CW-1:0]   bars_next;
	logic [CNTW-1:0] bars_ext;
	logic [CNTW-1:0] lb_cnt;
	logic [CNTW-1:0] ra_cnt;
	logic [CNTW-1:0] cnt_s_d;
	logic [CNTW-1:0] cnt_a_d;
	logic [CNTW-1:0] swing_last;
	logic [AW-1:0]   walk_last_d;

	logic [AW-1:0]   newest_q;
	logic [CNTW-1:0] cnt_s_q;
	logic [CNTW-1:0] cnt_a_q;
	logic [AW-1:0]   walk_last_q;
	logic [AW-1:0]   j_q;
	logic [AW-1:0]   rd_addr;

	logic                  rd_vld_s1;
	logic [AW-1:0]         j_s1;
	logic [PRICE_BITS-1:0] rd_h_s1;
	logic [PRICE_BITS-1:0] rd_l_s1;
	logic [PRICE_BITS-1:0] rd_c_s1;
	logic                  in_swing;
	logic                  atr_term;

	logic [PRICE_BITS-1:0] prev_h_q;
	logic [PRICE_BITS-1:0] prev_l_q;
	logic                  tr_vld_s2;
	logic [PRICE_BITS-1:0] d_hl_s2;
	logic [PRICE_BITS-1:0] d_hc_s2;
	logic [PRICE_BITS-1:0] d_lc_s2;
	logic [PRICE_BITS-1:0] tr_pair;
	logic [PRICE_BITS-1:0] tr_max;

	logic [PRICE_BITS-1:0] hi_acc_q;
	logic [PRICE_BITS-1:0] lo_acc_q;
	logic [SW-1:0]         sum_q;
	logic [PRICE_BITS-1:0] cls_q;
	logic [PRICE_BITS-1:0] range_q;

	logic                  div_done;
	logic [PRICE_BITS-1:0] atr;

	logic [PRODW-1:0]      p38_q;
	logic [PRODW-1:0]      p62_q;
	logic [LIMW-1:0]       lim_q;
	logic [PRICE_BITS-1:0] l38_q;
	logic [PRICE_BITS-1:0] l62_q;

	logic [PRICE_BITS-1:0] diff38;
	logic [PRICE_BITS-1:0] diff62;
	logic                  ok38;
	logic                  ok62;
	logic [1:0]            conf;

	logic                  res_vld_q;
	logic [1:0]            res_conf_q;
	logic [PRICE_BITS-1:0] res_l38_q;
	logic [PRICE_BITS-1:0] res_l62_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lb_q  <= RST_SWING_LOOKBACK;
			ra_q  <= RST_RANGE_AVG_LENGTH;
			tol_q <= RST_TOLERANCE_MULTIPLE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SWING_LOOKBACK:     lb_q  <= cfg_wdata[LB_W-1:0];
				REG_RANGE_AVG_LENGTH:   ra_q  <= cfg_wdata[RA_W-1:0];
				REG_TOLERANCE_MULTIPLE: tol_q <= cfg_wdata[TOL_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept       = bar_in.valid && cmd.take;
	assign bar_in.ready = cmd.take;

	// window lengths for the bar being accepted
	assign bars_next  = (bars_q == CW'(HISTORY_DEPTH)) ? bars_q : bars_q + 1'b1;
	assign bars_ext   = CNTW'(bars_next);
	assign lb_cnt     = CNTW'(lb_q) + 1'b1;
	assign ra_cnt     = CNTW'(ra_q) + 1'b1;
	assign cnt_s_d    = (lb_cnt < bars_ext) ? lb_cnt : bars_ext;
	assign cnt_a_d    = (ra_cnt < bars_ext - 1'b1) ? ra_cnt : bars_ext - 1'b1;
	assign swing_last = cnt_s_d - 1'b1;
	assign walk_last_d = (swing_last > cnt_a_d) ? swing_last[AW-1:0] : cnt_a_d[AW-1:0];

	// ring position j bars before the newest
	assign rd_addr = (newest_q >= j_q) ? newest_q - j_q :
		AW'((AW+1)'(newest_q) + (AW+1)'(HISTORY_DEPTH) - (AW+1)'(j_q));

	always_ff @(posedge clk) begin
		if (accept) begin
			hi_mem[wptr_q] <= bar_in.bar_high;
			lo_mem[wptr_q] <= bar_in.bar_low;
			cl_mem[wptr_q] <= bar_in.bar_close;
		end
		if (cmd.walk) begin
			rd_h_s1 <= hi_mem[rd_addr];
			rd_l_s1 <= lo_mem[rd_addr];
			rd_c_s1 <= cl_mem[rd_addr];
		end
	end

	// the close read at j belongs to the true range of the bar at j-1
	assign in_swing = CNTW'(j_s1) < cnt_s_q;
	assign atr_term = (j_s1 != '0) && (CNTW'(j_s1) <= cnt_a_q);

	assign tr_pair = (d_hl_s2 > d_hc_s2) ? d_hl_s2 : d_hc_s2;
	assign tr_max  = (tr_pair > d_lc_s2) ? tr_pair : d_lc_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q    <= '0;
			bars_q    <= '0;
			j_q       <= '0;
			rd_vld_s1 <= 1'b0;
			tr_vld_s2 <= 1'b0;
			res_vld_q <= 1'b0;
		end else begin
			if (accept) begin
				wptr_q <= (wptr_q == AW'(HISTORY_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
				bars_q <= bars_next;
				j_q    <= '0;
			end else if (cmd.walk) begin
				j_q <= j_q + 1'b1;
			end
			rd_vld_s1 <= cmd.walk;
			tr_vld_s2 <= rd_vld_s1 && atr_term;
			if (cmd.load) begin
				res_vld_q <= 1'b1;
			end else if (res_out.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			newest_q    <= wptr_q;
			cls_q       <= bar_in.bar_close;
			cnt_s_q     <= cnt_s_d;
			cnt_a_q     <= cnt_a_d;
			walk_last_q <= walk_last_d;
			hi_acc_q    <= '0;
			lo_acc_q    <= '1;
			sum_q       <= '0;
		end
		if (cmd.walk) begin
			j_s1 <= j_q;
		end
		if (rd_vld_s1) begin
			if (in_swing) begin
				if (rd_h_s1 > hi_acc_q) hi_acc_q <= rd_h_s1;
				if (rd_l_s1 < lo_acc_q) lo_acc_q <= rd_l_s1;
			end
			prev_h_q <= rd_h_s1;
			prev_l_q <= rd_l_s1;
			d_hl_s2  <= (prev_h_q >= prev_l_q) ? prev_h_q - prev_l_q : '0;
			d_hc_s2  <= (prev_h_q >= rd_c_s1) ? prev_h_q - rd_c_s1 : rd_c_s1 - prev_h_q;
			d_lc_s2  <= (prev_l_q >= rd_c_s1) ? prev_l_q - rd_c_s1 : rd_c_s1 - prev_l_q;
		end
		if (tr_vld_s2) begin
			sum_q <= sum_q + SW'(tr_max);
		end
		if (cmd.div_start) begin
			range_q <= hi_acc_q - lo_acc_q;
		end
		if (cmd.mul) begin
			p38_q <= {{FRAC_W{1'b0}}, range_q} * {{PRICE_BITS{1'b0}}, FRAC_382};
			p62_q <= {{FRAC_W{1'b0}}, range_q} * {{PRICE_BITS{1'b0}}, FRAC_618};
			lim_q <= {{TOL_W{1'b0}}, atr} * {{PRICE_BITS{1'b0}}, tol_q};
		end
		if (cmd.lvl) begin
			l38_q <= lo_acc_q + p38_q[PRODW-1:FRAC_W];
			l62_q <= lo_acc_q + p62_q[PRODW-1:FRAC_W];
		end
		if (cmd.load) begin
			res_conf_q <= conf;
			res_l38_q  <= l38_q;
			res_l62_q  <= l62_q;
		end
	end

	fra_div #(
		.DVD_W (SW),
		.DVS_W (CNTW),
		.QUO_W (PRICE_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (sum_q),
		.divisor  (cnt_a_q),
		.done     (div_done),
		.quotient (atr)
	);

	assign diff38 = (cls_q >= l38_q) ? cls_q - l38_q : l38_q - cls_q;
	assign diff62 = (cls_q >= l62_q) ? cls_q - l62_q : l62_q - cls_q;
	assign ok38   = LIMW'({diff38, 8'h00}) <= lim_q;
	assign ok62   = LIMW'({diff62, 8'h00}) <= lim_q;
	assign conf   = {1'b0, ok38} + {1'b0, ok62};

	assign res_out.valid            = res_vld_q;
	assign res_out.confluence_count = res_conf_q;
	assign res_out.level_382        = res_l38_q;
	assign res_out.level_618        = res_l62_q;

	assign sts.accepted  = accept;
	assign sts.first_bar = (bars_q == '0);
	assign sts.walk_end  = (j_q == walk_last_q);
	assign sts.pipe_busy = rd_vld_s1 || tr_vld_s2;
	assign sts.swing_ok  = hi_acc_q > lo_acc_q;
	assign sts.div_done  = div_done;
	assign sts.out_free  = !res_vld_q || res_out.ready;

endmodule

[src/fib_retrace_atr_confluence_core.sv]
// Top level of the retracement / true-range confluence detector.
// One bar request is taken at a time. The bar is written into single-port history
// memories, then the newest W+1 stored bars are read back one per cycle, where W is
// the larger of the swing window minus one and the range-average length (both limited
// by the bars stored), so W+1 is between 2 and HISTORY_DEPTH. A two-stage pipeline
// behind the memory read folds each bar into the swing high/low and the true-range sum;
// the average then comes from a restoring divider with a dividend of PRICE_BITS plus
// clog2(HISTORY_DEPTH+1) bits. After the walk the pipeline empties, then the divide,
// the multiply, the level step and the result load follow; the load waits while the
// result register still holds an unread result. The first bar and bars whose swing is
// flat or inverted give no result and free the block once the pipeline has emptied
// after the walk (or at once for the first bar). A finished result sits in an output
// register, so the next bar is taken while it waits. The histories need no clearing
// after reset; only entries already written are read.
module fib_retrace_atr_confluence_core import fra_pkg::*; #(
	parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
	parameter int PRICE_BITS    = DEF_PRICE_BITS
) (
	input  logic             clk,
	input  logic             arst_n,
	fra_bar_if.sink          bar_in,
	fra_res_if.source        res_out,
	input  logic             cfg_we,
	input  logic [IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata
);

	fra_cmd_t cmd;
	fra_sts_t sts;

	fra_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	fra_datapath #(
		.HISTORY_DEPTH (HISTORY_DEPTH),
		.PRICE_BITS    (PRICE_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.bar_in    (bar_in),
		.res_out   (res_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
